/* src/iols_pkg.sv */
// ============================================================================
// iols_pkg
// Shared types and constants for the indexed ordered list store.
// ============================================================================
package iols_pkg;

    localparam int DEFAULT_DEPTH = 64;

    localparam int DATA_W = 64;
    localparam int ACT_W  = 3;
    localparam int POS_W  = 8;
    localparam int OUT_W  = 7;

    // command codes
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP_HEAD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ERASE      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FIND       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd5;

    localparam logic [OUT_W-1:0]  NOT_FOUND = 7'h7F;
    localparam logic [DATA_W-1:0] READ_MISS = 64'hFFFF_FFFF_FFFF_8000;

    // what a cell loads on the next edge
    typedef enum logic [1:0] {
        MOVE_HOLD,
        MOVE_LOAD,
        MOVE_LEFT,
        MOVE_RIGHT
    } cell_move_t;

    typedef struct packed {
        cell_move_t move;
        logic       find_en;
        logic       read_sel;
    } cell_ctrl_t;

endpackage

/* src/iols_cell.sv */
// ============================================================================
// iols_cell
// One slot of the list: holds a value, shifts to/from neighbors, flags a hit.
// ============================================================================
module iols_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  iols_pkg::cell_ctrl_t        ctrl,
    input  logic [iols_pkg::DATA_W-1:0] new_value,
    input  logic [iols_pkg::DATA_W-1:0] left_value,
    input  logic [iols_pkg::DATA_W-1:0] right_value,
    input  logic [iols_pkg::DATA_W-1:0] key,
    output logic [iols_pkg::DATA_W-1:0] value,
    output logic                        hit
);

    logic [iols_pkg::DATA_W-1:0] value_reg;
    logic [iols_pkg::DATA_W-1:0] value_next;
    logic                        hit_reg;
    logic                        hit_next;

    always_comb
    begin
        unique case (ctrl.move)
            iols_pkg::MOVE_LOAD:  value_next = new_value;
            iols_pkg::MOVE_LEFT:  value_next = left_value;
            iols_pkg::MOVE_RIGHT: value_next = right_value;
            default:              value_next = value_reg;
        endcase
    end

    // find and read do not move data, so compare against the current value
    assign hit_next = ctrl.read_sel | (ctrl.find_en & (value_reg == key));

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

/* src/indexed_ordered_list_store.sv */
// ============================================================================
// indexed_ordered_list_store
// Ordered list of up to DEPTH signed 64-bit values in a shifting cell chain.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: action,
//   position, item_value. Output channel (out_valid/out_ready) returns one
//   result word per command: found_position, read_value, element_count,
//   list_empty, insert_dropped.
//   Insert, push, pop and erase shift the cell chain on the accept edge: cells
//   past the target take their left neighbor (insert); the target and cells
//   past it take their right neighbor (erase). Find and read latch a per-cell
//   hit bit on the accept edge; the next cycle reduces the hit bits
//   (lowest-hit encode, one-hot value select) into the output register.
//   Result path: the accept edge latches the hit bits and sets busy_reg; with
//   busy_reg set, the output register and out_valid are loaded.
//   No new command is taken while busy_reg is set, i.e. while the hit-reduce
//   stage between the cell chain and the output register is working.
//   A new command is taken on the edge that hands off the previous result
//   (out_ready high), so a stalled receiver holds off the next command.
//   Reset clears the element count, hit bits and handshake state; slot
//   contents are not cleared and are never visible beyond the count.
//   While out_valid is high and out_ready is low the result word holds and in_ready stays low.
// ============================================================================
module indexed_ordered_list_store #(
    parameter int DEPTH = iols_pkg::DEFAULT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [iols_pkg::ACT_W-1:0]  action,
    input  logic signed [iols_pkg::POS_W-1:0] position,
    input  logic signed [iols_pkg::DATA_W-1:0] item_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [iols_pkg::OUT_W-1:0]  found_position,
    output logic signed [iols_pkg::DATA_W-1:0] read_value,
    output logic [iols_pkg::OUT_W-1:0]  element_count,
    output logic                        list_empty,
    output logic                        insert_dropped
);

    localparam int IW = $clog2(DEPTH);        // slot index width
    localparam int CW = $clog2(DEPTH + 1);    // count width
    localparam int WW = CW + iols_pkg::POS_W + 1; // signed compare width
    localparam int DW = iols_pkg::DATA_W;

    // handshake / pipeline control
    logic accept;
    logic busy_reg;
    logic out_valid_reg;

    // list state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW+iols_pkg::OUT_W-1:0] count_w;

    // command held for the reduce cycle
    logic [iols_pkg::ACT_W-1:0] act_reg;
    logic                       dropped_reg;
    logic                       dropped_next;

    // output word
    logic [iols_pkg::OUT_W-1:0] found_reg;
    logic [DW-1:0]              read_reg;
    logic [iols_pkg::OUT_W-1:0] count_out_reg;
    logic                       empty_reg;
    logic                       drop_out_reg;

    // cell chain
    iols_pkg::cell_ctrl_t ctrl [DEPTH];
    logic [DW-1:0]        cell_value [DEPTH];
    logic [DW-1:0]        left_in [DEPTH];
    logic [DW-1:0]        right_in [DEPTH];
    logic [DEPTH-1:0]     hit_vec;

    // position decode
    logic signed [WW-1:0] pos_s;
    logic signed [WW-1:0] cnt_s;
    logic [WW-1:0]        ins_at_w;
    logic [IW-1:0]        ins_at;
    logic [IW-1:0]        pos_idx;
    logic                 pos_in_range;
    logic                 full;
    logic                 do_insert;
    logic                 do_erase;
    logic [IW-1:0]        target;

    // reduce stage
    logic [DEPTH-1:0]     low_hit;
    logic [IW-1:0]        hit_idx;
    logic [IW+iols_pkg::OUT_W-1:0] hit_idx_w;
    logic [DW-1:0]        sel_value;
    logic                 any_hit;

    assign accept   = in_valid & in_ready;
    assign in_ready = !busy_reg && (!out_valid_reg || out_ready);

    assign pos_s = {{(WW - iols_pkg::POS_W){position[iols_pkg::POS_W-1]}}, position};
    assign cnt_s = {{(WW - CW){1'b0}}, count_reg};
    assign full  = (count_reg == CW'(DEPTH));

    assign pos_in_range = (pos_s >= 0) && (pos_s < cnt_s);
    assign pos_idx      = pos_s[IW-1:0];

    always_comb
    begin
        // insert: front for non-positive or empty, append when past the end
        if ((pos_s <= 0) || (count_reg == '0))
        begin
            ins_at_w = '0;
        end
        else if (pos_s >= cnt_s)
        begin
            ins_at_w = cnt_s;
        end
        else
        begin
            ins_at_w = pos_s;
        end
    end

    assign ins_at = ins_at_w[IW-1:0];

    always_comb
    begin
        do_insert    = 1'b0;
        do_erase     = 1'b0;
        dropped_next = 1'b0;
        target       = '0;
        unique case (action)
            iols_pkg::ACT_PUSH_FRONT:
            begin
                do_insert    = !full;
                dropped_next = full;
            end
            iols_pkg::ACT_POP_HEAD:
            begin
                do_erase = (count_reg != '0);
            end
            iols_pkg::ACT_INSERT:
            begin
                do_insert    = !full;
                dropped_next = full;
                target       = ins_at;
            end
            iols_pkg::ACT_ERASE:
            begin
                do_erase = pos_in_range;
                target   = pos_idx;
            end
            default:
            begin
                do_insert = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (accept && do_erase)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // per-cell control
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctrl[i].move     = iols_pkg::MOVE_HOLD;
            ctrl[i].find_en  = accept && (action == iols_pkg::ACT_FIND)
                               && (CW'(i) < count_reg);
            ctrl[i].read_sel = accept && (action == iols_pkg::ACT_READ)
                               && pos_in_range && (IW'(i) == pos_idx);
            if (accept && do_insert)
            begin
                if (IW'(i) == target)
                begin
                    ctrl[i].move = iols_pkg::MOVE_LOAD;
                end
                else if (IW'(i) > target)
                begin
                    ctrl[i].move = iols_pkg::MOVE_LEFT;
                end
            end
            else if (accept && do_erase)
            begin
                if (IW'(i) >= target)
                begin
                    ctrl[i].move = iols_pkg::MOVE_RIGHT;
                end
            end
        end
    end

    // neighbor wiring; chain ends feed back harmless values
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            left_in[i]  = (i == 0) ? item_value : cell_value[(i == 0) ? 0 : i - 1];
            right_in[i] = (i == DEPTH - 1) ? cell_value[i]
                                           : cell_value[(i == DEPTH - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        iols_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[g]),
            .new_value   (item_value),
            .left_value  (left_in[g]),
            .right_value (right_in[g]),
            .key         (item_value),
            .value       (cell_value[g]),
            .hit         (hit_vec[g])
        );
    end

    // reduce: isolate lowest hit and encode it; OR-select the hit cells' values (one-hot on read)
    assign low_hit = hit_vec & (~hit_vec + DEPTH'(1));
    assign any_hit = |hit_vec;

    always_comb
    begin
        hit_idx   = '0;
        sel_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_idx   = hit_idx | ({IW{low_hit[i]}} & IW'(i));
            sel_value = sel_value | ({DW{hit_vec[i]}} & cell_value[i]);
        end
    end

    assign hit_idx_w = {{iols_pkg::OUT_W{1'b0}}, hit_idx};
    assign count_w   = {{iols_pkg::OUT_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg  <= accept;
            count_reg <= count_next;
            if (busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= action;
            dropped_reg <= dropped_next;
        end
        if (busy_reg)
        begin
            found_reg <= iols_pkg::NOT_FOUND;
            read_reg  <= '0;
            if (act_reg == iols_pkg::ACT_FIND && any_hit)
            begin
                found_reg <= hit_idx_w[iols_pkg::OUT_W-1:0];
            end
            if (act_reg == iols_pkg::ACT_READ)
            begin
                read_reg <= any_hit ? sel_value : iols_pkg::READ_MISS;
            end
            count_out_reg <= count_w[iols_pkg::OUT_W-1:0];
            empty_reg     <= (count_reg == '0);
            drop_out_reg  <= dropped_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found_position = found_reg;
    assign read_value     = read_reg;
    assign element_count  = count_out_reg;
    assign list_empty     = empty_reg;
    assign insert_dropped = drop_out_reg;

endmodule
